[rtl/sha256_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 package
// Shared constants, round table, initial hash words and command struct.
// ---------------------------------------------------------------------------
package sha256_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenOffset  = 56;
   localparam logic [7:0]  PadByte    = 8'h80;

   typedef struct packed {
      logic       write_byte;   // store byte_value at byte_addr
      logic [7:0] byte_value;
      logic [5:0] byte_addr;
      logic       load_block;   // load working vars from hash
      logic       do_round;     // run one round
      logic [5:0] round_idx;
      logic       fold_hash;    // add working vars into hash
      logic       init_hash;    // return hash to initial values
   } dp_cmd_type;

   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k [0:63];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
         32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
         32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
         32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
         32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
         32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
         32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
         32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
         32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[idx];
   endfunction

   function automatic logic [31:0] init_hash_word(input logic [2:0] idx);
      logic [31:0] h [0:7];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[idx];
   endfunction

endpackage
`default_nettype wire

[rtl/sha256_message_hasher.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-stream SHA-256 with padding and eight-word digest output.
// ---------------------------------------------------------------------------
// Usage: send message bytes on the req_ channel with req_kind low; send an
// item with req_kind high to finish. Each item is taken when req_valid is
// high and req_stall is low. Bytes are taken one per cycle, except that
// the 64th byte of a block starts a compression (load, 64 rounds at one
// round per cycle, fold) during which req_stall is high. A finish item
// writes the pad bytes one per cycle, compresses one or two blocks, then
// shows the eight digest words on rsp_ in order, word 0 first, rsp_last on
// word 7. A stall on rsp_ holds the current word; nothing is taken on req_
// until the digest is done and the hash has returned to its initial
// values. Reset (synchronous, active high) starts an empty message with the
// standard initial hash.
// ---------------------------------------------------------------------------
module sha256_message_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last
);

   sha256_pkg::dp_cmd_type cmd;
   logic [2:0] hash_sel;

   sha256_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_data_byte,
      .rsp_valid, .rsp_stall, .rsp_word_index, .rsp_last, .cmd, .hash_sel
   );

   sha256_datapath u_dp (
      .clock, .reset, .cmd, .hash_sel, .hash_word(rsp_digest_word)
   );

endmodule
`default_nettype wire

[rtl/sha256_datapath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 datapath
// Block bytes gather straight into the 16-word schedule window; one round
// per cycle.
// ---------------------------------------------------------------------------
module sha256_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sha256_pkg::dp_cmd_type cmd,
   input  wire logic [2:0]           hash_sel,
   output logic [31:0]               hash_word
);

   logic [31:0] w_ff [0:15];
   logic [31:0] v_ff [0:7];
   logic [31:0] h_ff [0:7];
   logic [31:0] w_cur, w15, w2, sm0, sm1, big0, big1, ch, maj, t1, t2;
   logic [3:0]  t4;

   // round logic
   always_comb begin
      t4   = cmd.round_idx[3:0];
      w15  = w_ff[4'(t4 + 4'd1)];
      w2   = w_ff[4'(t4 + 4'd14)];
      sm0  = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
      sm1  = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
      if (cmd.round_idx < 6'd16) begin
         w_cur = w_ff[t4];
      end else begin
         w_cur = w_ff[t4] + sm0 + w_ff[4'(t4 + 4'd9)] + sm1;
      end
      big1 = {v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]}
           ^ {v_ff[4][24:0], v_ff[4][31:25]};
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + big1 + ch + sha256_pkg::round_const(cmd.round_idx) + w_cur;
      big0 = {v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]}
           ^ {v_ff[0][21:0], v_ff[0][31:22]};
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = big0 + maj;
   end

   // schedule and working vars; a byte lands big-endian in its word
   always_ff @(posedge clock) begin
      if (cmd.write_byte) begin
         w_ff[cmd.byte_addr[5:2]][{~cmd.byte_addr[1:0], 3'b000} +: 8] <= cmd.byte_value;
      end else if (cmd.load_block) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= h_ff[i];
         end
      end else if (cmd.do_round) begin
         w_ff[t4] <= w_cur;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   // hash state
   always_ff @(posedge clock) begin
      if (reset || cmd.init_hash) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= sha256_pkg::init_hash_word(3'(i));
         end
      end else if (cmd.fold_hash) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= h_ff[i] + v_ff[i];
         end
      end
   end

   assign hash_word = h_ff[hash_sel];

endmodule
`default_nettype wire

[rtl/sha256_control.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, rounds and digest output.
// ---------------------------------------------------------------------------
module sha256_control (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_kind,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_word_index,
   output logic            rsp_last,
   output sha256_pkg::dp_cmd_type cmd,
   output logic [2:0]      hash_sel
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_ROUND = 7'b0000100,
      ST_FOLD  = 7'b0001000,
      ST_PAD   = 7'b0010000,
      ST_OUT   = 7'b0100000,
      ST_CLR   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  round_ff, round_in;
   logic [6:0]  pad_ff, pad_in;    // next pad address, 64 = done
   logic        final_ff, final_in; // current compression is the last one
   logic [2:0]  widx_ff, widx_in;
   logic        pad_len;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_word_index = widx_ff;
   assign rsp_last = (widx_ff == 3'd7);
   assign hash_sel = widx_ff;

   // pad byte for current address; length bytes only in the last block
   always_comb begin
      pad_len = (pad_ff[5:0] >= 6'(sha256_pkg::LenOffset)) && final_in;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      round_in = round_ff;
      pad_in   = pad_ff;
      final_in = final_ff;
      widx_in  = widx_ff;
      cmd      = '0;
      cmd.round_idx = round_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.write_byte = 1'b1;
               cmd.byte_addr  = fill_ff;
               if (!req_kind) begin
                  cmd.byte_value = req_data_byte;
                  fill_in = fill_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
                  if (fill_ff == 6'd63) begin
                     final_in = 1'b0;
                     state_in = ST_LOAD;
                  end
               end else begin
                  cmd.byte_value = sha256_pkg::PadByte;
                  pad_in   = 7'(fill_ff) + 7'd1;
                  final_in = (fill_ff < 6'd56);
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (pad_ff[6]) begin
               state_in = ST_LOAD;
            end else begin
               cmd.write_byte = 1'b1;
               cmd.byte_addr  = pad_ff[5:0];
               cmd.byte_value = pad_len
                  ? bits_ff[8*(7-(pad_ff[2:0])) +: 8] : 8'd0;
               pad_in = pad_ff + 7'd1;
            end
         end
         ST_LOAD: begin
            cmd.load_block = 1'b1;
            round_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold_hash = 1'b1;
            if (!final_ff) begin
               if (fill_ff == 6'd0 && pad_ff[6] == 1'b0) begin
                  state_in = ST_IDLE;
               end else begin
                  // second padding block
                  final_in = 1'b1;
                  pad_in   = 7'd0;
                  state_in = ST_PAD;
               end
            end else begin
               widx_in  = 3'd0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == 3'd7) begin
                  state_in = ST_CLR;
               end
            end
         end
         ST_CLR: begin
            cmd.init_hash = 1'b1;
            fill_in  = '0;
            bits_in  = '0;
            pad_in   = '0;
            final_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         round_ff <= '0;
         pad_ff   <= '0;
         final_ff <= 1'b0;
         widx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         round_ff <= round_in;
         pad_ff   <= pad_in;
         final_ff <= final_in;
         widx_ff  <= widx_in;
      end
   end

   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> req_stall) else $error("accept during rounds");
   a_out_after_fold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_FOLD && widx_ff == 3'd0))
      else $error("digest without fold");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && !rsp_stall) |=> (state_ff == ST_CLR))
      else $error("no clear after digest");

endmodule
`default_nettype wire
